>>> rtl/core/rpn_pkg.sv
// ============================================================================
// rpn_pkg - relative path normaliser shared definitions
// Character codes, status codes and the result record used by the
// normaliser and its checker.
// ============================================================================
package rpn_pkg;

    // Characters of interest
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Status codes carried by the final result of a path
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_ABSOLUTE = 3'd2;
    localparam logic [2:0] ST_NUL      = 3'd3;
    localparam logic [2:0] ST_LINEBRK  = 3'd4;
    localparam logic [2:0] ST_PARENT   = 3'd5;
    localparam logic [2:0] ST_NOCOMP   = 3'd6;

    // Most results one request can produce: separator, two dots, byte
    localparam int RES_MAX = 4;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_has_byte;
        logic       out_last;
        logic [2:0] status;
    } rpn_res_t;

endpackage : rpn_pkg

>>> rtl/core/rpn_if.sv
// ============================================================================
// rpn_if - request channels of the relative path normaliser
// Input channel carries path bytes, output channel carries normalised
// bytes and the final status.
// ============================================================================
interface rpn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       has_byte;
    logic       end_of_path;

    modport source (output valid, in_byte, has_byte, end_of_path, input ready);
    modport sink   (input valid, in_byte, has_byte, end_of_path, output ready);
endinterface : rpn_in_if

interface rpn_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_has_byte;
    logic       out_last;
    logic [2:0] status;

    modport source (output valid, out_byte, out_has_byte, out_last, status,
                    input ready);
    modport sink   (input valid, out_byte, out_has_byte, out_last, status,
                    output ready);
    modport mon    (input valid, ready, out_byte, out_has_byte, out_last, status);
endinterface : rpn_out_if

>>> rtl/core/relative_path_normalizer.sv
// ============================================================================
// relative_path_normalizer - streaming relative path normaliser
// Collapses slash runs, drops empty and "." components, holds leading dots
// back, and closes each path with a status code.
// ============================================================================
//
//  channel  dir  payload                                   handshake
//  -------  ---  ----------------------------------------  ------------
//  in_ch    in   in_byte, has_byte, end_of_path            valid/ready
//  out_ch   out  out_byte, out_has_byte, out_last, status  valid/ready
//
//  One request per cycle enters the input register while in_ch.ready is high;
//  there it is processed and, once the queue has room, its 0..4 results are
//  written to the result queue. Results leave one per cycle while out_ch.ready
//  is high; the up to three extra results of a separator plus held dots are
//  absorbed by the FIFO_DEPTH-entry queue. in_ch.ready drops only while the
//  queue has fewer than four free entries. rst_n clears path state, the input
//  register and the queue asynchronously.
module relative_path_normalizer #(
    parameter int FIFO_DEPTH = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    rpn_in_if.sink    in_ch,
    rpn_out_if.source out_ch
);
    import rpn_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // Input register
    logic       stg_valid_reg;
    logic [7:0] stg_byte_reg;
    logic       stg_has_reg;
    logic       stg_end_reg;

    // Path state
    logic [1:0] held_dots_reg,      held_dots_next;
    logic       component_open_reg, component_open_next;
    logic       any_component_reg,  any_component_next;
    logic       seen_any_reg,       seen_any_next;
    logic [2:0] char_error_reg,     char_error_next;
    logic       parent_seen_reg,    parent_seen_next;

    // Result queue
    rpn_res_t   fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg,  count_next;

    rpn_res_t   res [RES_MAX];
    logic [2:0] n_res;
    logic       stg_fire;
    logic       out_fire;
    logic       room;

    assign room     = (count_reg <= CNT_W'(FIFO_DEPTH - RES_MAX));
    assign stg_fire = stg_valid_reg && room;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign in_ch.ready = !stg_valid_reg || room;

    // Input register load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            stg_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            stg_byte_reg <= in_ch.in_byte;
            stg_has_reg  <= in_ch.has_byte;
            stg_end_reg  <= in_ch.end_of_path;
        end
    end

    // Per-request processing: next path state and up to four results
    always_comb
    begin
        logic       first;
        logic [2:0] k;
        logic [2:0] st;

        held_dots_next      = held_dots_reg;
        component_open_next = component_open_reg;
        any_component_next  = any_component_reg;
        seen_any_next       = seen_any_reg;
        char_error_next     = char_error_reg;
        parent_seen_next    = parent_seen_reg;
        for (int i = 0; i < RES_MAX; i++)
        begin
            res[i] = '0;
        end
        k     = 3'd0;
        st    = ST_OK;
        first = !seen_any_reg;

        if (stg_has_reg)
        begin
            seen_any_next = 1'b1;
            if (char_error_reg != ST_OK)
            begin
                // error latched: byte is swallowed
            end
            else if (first && stg_byte_reg == CH_SLASH)
            begin
                char_error_next = ST_ABSOLUTE;
            end
            else if (stg_byte_reg == CH_NUL)
            begin
                char_error_next = ST_NUL;
            end
            else if (stg_byte_reg == CH_LF || stg_byte_reg == CH_CR)
            begin
                char_error_next = ST_LINEBRK;
            end
            else if (stg_byte_reg == CH_SLASH)
            begin
                if (!component_open_reg && held_dots_reg == 2'd2)
                begin
                    parent_seen_next = 1'b1;
                end
                held_dots_next      = 2'd0;
                component_open_next = 1'b0;
            end
            else if (stg_byte_reg == CH_DOT && !component_open_reg &&
                     held_dots_reg < 2'd2)
            begin
                held_dots_next = held_dots_reg + 2'd1;
            end
            else
            begin
                // opening a component: separator, then held dots
                if (!component_open_reg)
                begin
                    if (any_component_reg)
                    begin
                        res[k[1:0]] = '{CH_SLASH, 1'b1, 1'b0, ST_OK};
                        k = k + 3'd1;
                    end
                    if (held_dots_reg >= 2'd1)
                    begin
                        res[k[1:0]] = '{CH_DOT, 1'b1, 1'b0, ST_OK};
                        k = k + 3'd1;
                    end
                    if (held_dots_reg == 2'd2)
                    begin
                        res[k[1:0]] = '{CH_DOT, 1'b1, 1'b0, ST_OK};
                        k = k + 3'd1;
                    end
                    held_dots_next      = 2'd0;
                    component_open_next = 1'b1;
                    any_component_next  = 1'b1;
                end
                res[k[1:0]] = '{stg_byte_reg, 1'b1, 1'b0, ST_OK};
                k = k + 3'd1;
            end
            if (parent_seen_next)
            begin
                k = 3'd0;
            end
        end

        // End of path: status, final flag, state back to reset
        if (stg_end_reg)
        begin
            if (!component_open_next && held_dots_next == 2'd2)
            begin
                parent_seen_next = 1'b1;
            end
            if (!seen_any_next)
            begin
                st = ST_EMPTY;
            end
            else if (char_error_next != ST_OK)
            begin
                st = char_error_next;
            end
            else if (parent_seen_next)
            begin
                st = ST_PARENT;
            end
            else if (!any_component_next)
            begin
                st = ST_NOCOMP;
            end
            else
            begin
                st = ST_OK;
            end

            if (st != ST_OK)
            begin
                k = 3'd0;
            end
            if (k != 3'd0)
            begin
                res[2'(k - 3'd1)].out_last = 1'b1;
                res[2'(k - 3'd1)].status   = st;
            end
            else
            begin
                res[0] = '{8'h00, 1'b0, 1'b1, st};
                k = 3'd1;
            end

            held_dots_next      = 2'd0;
            component_open_next = 1'b0;
            any_component_next  = 1'b0;
            seen_any_next       = 1'b0;
            char_error_next     = ST_OK;
            parent_seen_next    = 1'b0;
        end

        n_res = k;
    end

    // Path state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_dots_reg      <= 2'd0;
            component_open_reg <= 1'b0;
            any_component_reg  <= 1'b0;
            seen_any_reg       <= 1'b0;
            char_error_reg     <= ST_OK;
            parent_seen_reg    <= 1'b0;
        end
        else if (stg_fire)
        begin
            held_dots_reg      <= held_dots_next;
            component_open_reg <= component_open_next;
            any_component_reg  <= any_component_next;
            seen_any_reg       <= seen_any_next;
            char_error_reg     <= char_error_next;
            parent_seen_reg    <= parent_seen_next;
        end
    end

    // Result queue storage
    always_ff @(posedge clk)
    begin
        if (stg_fire)
        begin
            for (int i = 0; i < RES_MAX; i++)
            begin
                if (3'(i) < n_res)
                begin
                    fifo_reg[wr_ptr_reg + PTR_W'(i)] <= res[i];
                end
            end
        end
    end

    // Result queue pointers and fill count
    always_comb
    begin
        count_next = count_reg;
        if (stg_fire)
        begin
            count_next = count_next + CNT_W'(n_res);
        end
        if (out_fire)
        begin
            count_next = count_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (stg_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_res);
            end
            if (out_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Output channel
    assign out_ch.valid        = (count_reg != '0);
    assign out_ch.out_byte     = fifo_reg[rd_ptr_reg].out_byte;
    assign out_ch.out_has_byte = fifo_reg[rd_ptr_reg].out_has_byte;
    assign out_ch.out_last     = fifo_reg[rd_ptr_reg].out_last;
    assign out_ch.status       = fifo_reg[rd_ptr_reg].status;

endmodule : relative_path_normalizer

>>> rtl/core/rpn_checker.sv
// ============================================================================
// rpn_checker - output channel checks for the relative path normaliser
// Watches the result channel for well-formed status and framing.
// ============================================================================
module rpn_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       ready,
    input logic [7:0] out_byte,
    input logic       out_has_byte,
    input logic       out_last,
    input logic [2:0] status
);
    import rpn_pkg::*;

    // Only the final result of a path carries a status
    a_status_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !out_last |-> status == ST_OK)
        else $error("status set on a non-final result");

    // A result without a byte is always the status-only final result
    a_bare_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !out_has_byte |-> out_last)
        else $error("byte-less result not marked final");

    // A final result that still carries a byte means the path was good
    a_byte_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
        valid && out_last && out_has_byte |-> status == ST_OK)
        else $error("error status on a result that carries a byte");

    // Status codes stay within the defined set
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> status <= ST_NOCOMP)
        else $error("undefined status code");

    // A stalled result is held
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(out_byte)
        && $stable(out_last) && $stable(status))
        else $error("stalled result changed");

endmodule : rpn_checker

bind relative_path_normalizer rpn_checker u_rpn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (out_ch.valid),
    .ready        (out_ch.ready),
    .out_byte     (out_ch.out_byte),
    .out_has_byte (out_ch.out_has_byte),
    .out_last     (out_ch.out_last),
    .status       (out_ch.status)
);

>>> verif/tb_relative_path_normalizer.sv
// ============================================================================
// tb_relative_path_normalizer - self-checking bench for the path normaliser
// A directed table of paths (empty, absolute, NUL, line break, parent, no
// component, extreme bytes) is followed by random paths built mostly from
// well-formed components. Table rows are checked against their typed-in
// results and all other results against a behavioural normaliser, with random
// idling on both channels and one long output hold-off that backs the block up.
// ============================================================================
`timescale 1ns / 1ps

module tb_relative_path_normalizer;

    import rpn_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 4;
    localparam int N_RANDOM     = 350;
    localparam int PRESSURE_AT  = 120;   // requests sent before the hold-off
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all
    localparam int MAX_REPORTS  = 10;
    localparam int N_DIRECTED   = 25;

    // One input request plus, for table rows, a typed-in expected result
    typedef struct packed {
        logic [7:0] b;
        logic       has;
        logic       eop;
        logic       fixed;
        rpn_res_t   want;
    } path_req_t;

    localparam rpn_res_t NO_RES = '0;

    // Directed table: rows with fixed set carry their single result
    localparam path_req_t DIRECTED [N_DIRECTED] = '{
        '{8'h00,    1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_EMPTY}},    // empty path
        '{CH_SLASH, 1'b1, 1'b0, 1'b0, NO_RES},                             // leading slash
        '{8'h00,    1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_ABSOLUTE}},
        '{8'h61,    1'b1, 1'b0, 1'b0, NO_RES},                             // "a"
        '{8'hA5,    1'b0, 1'b0, 1'b0, NO_RES},                             // idle
        '{CH_NUL,   1'b1, 1'b0, 1'b0, NO_RES},
        '{8'h00,    1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_NUL}},
        '{CH_LF,    1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_LINEBRK}},
        '{CH_CR,    1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_LINEBRK}},
        '{CH_DOT,   1'b1, 1'b0, 1'b0, NO_RES},                             // ".."
        '{CH_DOT,   1'b1, 1'b0, 1'b0, NO_RES},
        '{8'h00,    1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_PARENT}},
        '{CH_DOT,   1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_NOCOMP}},   // "."
        '{8'hFF,    1'b1, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, ST_OK}},
        '{8'h78,    1'b1, 1'b0, 1'b0, NO_RES},                             // "x//..y/../z"
        '{CH_SLASH, 1'b1, 1'b0, 1'b0, NO_RES},
        '{CH_SLASH, 1'b1, 1'b0, 1'b0, NO_RES},
        '{CH_DOT,   1'b1, 1'b0, 1'b0, NO_RES},
        '{CH_DOT,   1'b1, 1'b0, 1'b0, NO_RES},
        '{8'h79,    1'b1, 1'b0, 1'b0, NO_RES},                             // four results
        '{CH_SLASH, 1'b1, 1'b0, 1'b0, NO_RES},
        '{CH_DOT,   1'b1, 1'b0, 1'b0, NO_RES},
        '{CH_DOT,   1'b1, 1'b0, 1'b0, NO_RES},
        '{CH_SLASH, 1'b1, 1'b0, 1'b0, NO_RES},
        '{8'h7A,    1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_PARENT}}
    };

    logic clk = 1'b0;
    logic rst_n;

    rpn_in_if  in_ch ();
    rpn_out_if out_ch ();

    relative_path_normalizer u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Behavioural normaliser state
    logic [1:0] nm_dots;
    logic       nm_open;
    logic       nm_any;
    logic       nm_seen;
    logic [2:0] nm_err;      // ST_OK while no character error is latched
    logic       nm_parent;

    rpn_res_t  step_out [$];       // results of the request just taken
    rpn_res_t  norm_expect_q [$];  // normalised results still to arrive
    path_req_t stim_q [$];

    int gen_reqs    = 0;
    int path_bytes  = 0;
    int req_sent    = 0;
    int paths_sent  = 0;
    int res_seen    = 0;
    int err_count   = 0;
    int status_hits [8];
    bit held_off    = 1'b0;

    function automatic rpn_res_t byte_res(input logic [7:0] b);
        rpn_res_t r;
        r = '0;
        r.out_byte     = b;
        r.out_has_byte = 1'b1;
        return r;
    endfunction

    task automatic clear_path();
        nm_dots   = 2'd0;
        nm_open   = 1'b0;
        nm_any    = 1'b0;
        nm_seen   = 1'b0;
        nm_err    = ST_OK;
        nm_parent = 1'b0;
    endtask

    // Normalise one request into step_out
    task automatic normalise_step(input logic [7:0] b, input logic has, input logic eop);
        logic       first;
        logic [2:0] st;
        rpn_res_t   r;
        int         i;
        step_out.delete();
        if (has)
        begin
            first   = !nm_seen;
            nm_seen = 1'b1;
            if (nm_err != ST_OK)
            begin
                // error latched: byte is swallowed
            end
            else if (first && b == CH_SLASH)
                nm_err = ST_ABSOLUTE;
            else if (b == CH_NUL)
                nm_err = ST_NUL;
            else if (b == CH_LF || b == CH_CR)
                nm_err = ST_LINEBRK;
            else
            begin
                if (b == CH_SLASH)
                begin
                    if (!nm_open && nm_dots == 2'd2)
                        nm_parent = 1'b1;
                    nm_dots = 2'd0;
                    nm_open = 1'b0;
                end
                else if (b == CH_DOT && !nm_open && nm_dots < 2'd2)
                    nm_dots = nm_dots + 2'd1;
                else
                begin
                    // first real byte of a component releases separator and dots
                    if (!nm_open)
                    begin
                        if (nm_any)
                            step_out = {step_out, byte_res(CH_SLASH)};
                        for (i = 0; i < int'(nm_dots); i++)
                            step_out = {step_out, byte_res(CH_DOT)};
                        nm_dots = 2'd0;
                        nm_open = 1'b1;
                        nm_any  = 1'b1;
                    end
                    step_out = {step_out, byte_res(b)};
                end
                if (nm_parent)
                    step_out.delete();
            end
        end
        if (eop)
        begin
            if (!nm_open && nm_dots == 2'd2)
                nm_parent = 1'b1;
            if (!nm_seen)
                st = ST_EMPTY;
            else if (nm_err != ST_OK)
                st = nm_err;
            else if (nm_parent)
                st = ST_PARENT;
            else if (!nm_any)
                st = ST_NOCOMP;
            else
                st = ST_OK;
            if (st != ST_OK)
                step_out.delete();
            if (step_out.size() > 0)
            begin
                r = step_out.pop_back();
            end
            else
            begin
                r = '0;
            end
            r.out_last = 1'b1;
            r.status   = st;
            step_out = {step_out, r};
            clear_path();
        end
    endtask

    // Idle gaps: mostly none or short, a few long, with idle-free stretches
    function automatic int next_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(39) == 0)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] name_char();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 8'h61 + 8'($urandom_range(25));
        if (r < 92)
            return 8'($urandom_range(32, 126));
        return 8'($urandom_range(255));
    endfunction

    // Queue one path byte, sometimes behind an idle request
    task automatic add_byte(input logic [7:0] b);
        path_req_t r;
        r = '0;
        if ($urandom_range(15) == 0)
        begin
            r.b = 8'($urandom_range(255));
            stim_q = {stim_q, r};
        end
        r.b   = b;
        r.has = 1'b1;
        stim_q = {stim_q, r};
        path_bytes++;
        gen_reqs++;
    endtask

    // One random path: mostly well-formed components, some noise
    task automatic gen_path();
        int        mode;
        int        ncomp;
        int        kind;
        int        len;
        int        j;
        int        k;
        path_req_t r;
        path_bytes = 0;
        mode = $urandom_range(99);
        if (mode < 8)
        begin
            len = $urandom_range(6);
            for (j = 0; j < len; j++)
                add_byte(8'($urandom_range(255)));
        end
        else
        begin
            if ($urandom_range(24) == 0)
                add_byte(CH_SLASH);
            ncomp = $urandom_range(1, 5);
            for (k = 0; k < ncomp; k++)
            begin
                if (k > 0)
                begin
                    len = ($urandom_range(4) == 0) ? $urandom_range(2, 4) : 1;
                    for (j = 0; j < len; j++)
                        add_byte(CH_SLASH);
                end
                kind = $urandom_range(99);
                if (kind < 8)
                    add_byte(CH_DOT);
                else if (kind < 12)
                begin
                    add_byte(CH_DOT);
                    add_byte(CH_DOT);
                end
                else if (kind >= 17)
                begin
                    // names, some with leading dots; 12..16 leaves an empty one
                    if (kind < 30)
                    begin
                        len = $urandom_range(1, 3);
                        for (j = 0; j < len; j++)
                            add_byte(CH_DOT);
                    end
                    len = (kind < 30 && $urandom_range(1) == 0) ? 0 : $urandom_range(1, 6);
                    for (j = 0; j < len; j++)
                        add_byte(name_char());
                end
            end
            if ($urandom_range(7) == 0)
                add_byte(CH_SLASH);
        end
        // close on the last byte or with a bare end marker
        if (path_bytes > 0 && $urandom_range(1) == 0)
        begin
            r = stim_q.pop_back();
            r.eop = 1'b1;
            stim_q = {stim_q, r};
        end
        else
        begin
            r     = '0;
            r.b   = 8'($urandom_range(255));
            r.eop = 1'b1;
            stim_q = {stim_q, r};
            gen_reqs++;
        end
    endtask

    // Result check against the oldest expectation
    always @(posedge clk)
    begin : result_check
        rpn_res_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            res_seen++;
            if (out_ch.out_last)
                status_hits[out_ch.status]++;
            if (norm_expect_q.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected result: byte %02h has %0b last %0b status %0d",
                             out_ch.out_byte, out_ch.out_has_byte, out_ch.out_last,
                             out_ch.status);
            end
            else
            begin
                want = norm_expect_q.pop_front();
                if (out_ch.out_byte !== want.out_byte ||
                    out_ch.out_has_byte !== want.out_has_byte ||
                    out_ch.out_last !== want.out_last ||
                    out_ch.status !== want.status)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("result %0d wrong: exp %02h/%0b/%0b/%0d got %02h/%0b/%0b/%0d",
                                 res_seen, want.out_byte, want.out_has_byte,
                                 want.out_last, want.status, out_ch.out_byte,
                                 out_ch.out_has_byte, out_ch.out_last, out_ch.status);
                end
            end
        end
    end

    // Watchdog on handshake activity
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("relative_path_normalizer: mismatch");
        $finish;
    end

    // Output side: random stalls plus one long hold-off
    initial
    begin : result_sink
        int gap;
        int calm;
        calm = 0;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held_off && req_sent >= PRESSURE_AT)
            begin
                held_off = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = next_gap(calm);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
        end
    end

    // Reset, stimulus, drain and verdict
    initial
    begin : main
        int        gap;
        int        calm;
        int        i;
        path_req_t r;
        calm              = 0;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.in_byte     = 8'h00;
        in_ch.has_byte    = 1'b0;
        in_ch.end_of_path = 1'b0;
        foreach (status_hits[i])
            status_hits[i] = 0;
        clear_path();

        for (i = 0; i < N_DIRECTED; i++)
            stim_q = {stim_q, DIRECTED[i]};
        while (gen_reqs < N_RANDOM)
            gen_path();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Send every request, predicting on acceptance
        foreach (stim_q[i])
        begin
            r   = stim_q[i];
            gap = next_gap(calm);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_ch.valid       <= 1'b1;
            in_ch.in_byte     <= r.b;
            in_ch.has_byte    <= r.has;
            in_ch.end_of_path <= r.eop;
            @(posedge clk);
            while (!in_ch.ready)
                @(posedge clk);
            normalise_step(r.b, r.has, r.eop);
            if (r.fixed)
                norm_expect_q = {norm_expect_q, r.want};
            else
                foreach (step_out[k])
                    norm_expect_q = {norm_expect_q, step_out[k]};
            if (r.has || r.eop)
                req_sent++;
            if (r.eop)
                paths_sent++;
        end
        in_ch.valid <= 1'b0;

        while (norm_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d paths in %0d requests, %0d results checked, %0d failures",
                 paths_sent, req_sent, res_seen, err_count);
        $display("final status seen: ok %0d empty %0d absolute %0d nul %0d",
                 status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_ABSOLUTE],
                 status_hits[ST_NUL]);
        $display("  break %0d parent %0d none %0d",
                 status_hits[ST_LINEBRK], status_hits[ST_PARENT], status_hits[ST_NOCOMP]);
        if (err_count == 0 && norm_expect_q.size() == 0)
            $display("relative_path_normalizer: match");
        else
            $display("relative_path_normalizer: mismatch");
        $finish;
    end

endmodule : tb_relative_path_normalizer
